// ===== rtl/core/spd_pkg.sv =====
// Shared constants, codes and helper function of the sample packet deframer.
`timescale 1ns / 1ps

package spd_pkg;

    localparam int SAMPLES_PER_PACKET = 512;
    localparam int MAX_CHANNELS       = 16;
    localparam int PACKET_WORDS       = SAMPLES_PER_PACKET + 4;
    localparam int POS_W              = $clog2(PACKET_WORDS);
    localparam int GRP_W              = $clog2(SAMPLES_PER_PACKET + 1);
    localparam int NUM_ENTRIES        = 16;
    localparam int ENTRY_W            = 4;
    localparam int WORD_W             = 16;
    localparam int VALUE_W            = 21;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 64;

    localparam logic [WORD_W-1:0]  HEADER_WORD = 16'hF0AA;
    localparam logic [VALUE_W-1:0] QMAX        = 21'd655360;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_STATUS = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic {
        ERR_HEADER   = 1'b0,
        ERR_SEQUENCE = 1'b1
    } t_err;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CHANNEL_COUNT = 3'd0,
        REG_CHANNEL_TABLE = 3'd1,
        REG_OUTPUT_MODE   = 3'd2,
        REG_RANGE_SELECT  = 3'd3,
        REG_LINE_LIMIT    = 3'd4,
        REG_SHOW_STATUS   = 3'd5,
        REG_START_COUNT   = 3'd6
    } t_reg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } t_state;

    // Whole scan groups that fit in one packet for a group size of 1 to 16.
    function automatic logic [GRP_W-1:0] groups_per_packet(input logic [4:0] gs);
        logic [GRP_W-1:0] r;
        r = GRP_W'(SAMPLES_PER_PACKET);
        unique case (gs)
            5'd2:    r = GRP_W'(SAMPLES_PER_PACKET / 2);
            5'd3:    r = GRP_W'(SAMPLES_PER_PACKET / 3);
            5'd4:    r = GRP_W'(SAMPLES_PER_PACKET / 4);
            5'd5:    r = GRP_W'(SAMPLES_PER_PACKET / 5);
            5'd6:    r = GRP_W'(SAMPLES_PER_PACKET / 6);
            5'd7:    r = GRP_W'(SAMPLES_PER_PACKET / 7);
            5'd8:    r = GRP_W'(SAMPLES_PER_PACKET / 8);
            5'd9:    r = GRP_W'(SAMPLES_PER_PACKET / 9);
            5'd10:   r = GRP_W'(SAMPLES_PER_PACKET / 10);
            5'd11:   r = GRP_W'(SAMPLES_PER_PACKET / 11);
            5'd12:   r = GRP_W'(SAMPLES_PER_PACKET / 12);
            5'd13:   r = GRP_W'(SAMPLES_PER_PACKET / 13);
            5'd14:   r = GRP_W'(SAMPLES_PER_PACKET / 14);
            5'd15:   r = GRP_W'(SAMPLES_PER_PACKET / 15);
            5'd16:   r = GRP_W'(SAMPLES_PER_PACKET / 16);
            default: r = GRP_W'(SAMPLES_PER_PACKET);
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/spd_word_if.sv =====
// Input channel carrying one packet word and the restart flag.
`timescale 1ns / 1ps

interface spd_word_if;
    import spd_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] packet_word;
    logic              restart;

    modport source (output valid, output packet_word, output restart, input ready);
    modport sink   (input valid, input packet_word, input restart, output ready);
endinterface

// ===== rtl/core/spd_result_if.sv =====
// Output channel carrying one result word.
`timescale 1ns / 1ps

interface spd_result_if;
    import spd_pkg::*;

    logic                      valid;
    logic                      ready;
    t_kind                     kind;
    logic signed [VALUE_W-1:0] value;
    logic [ENTRY_W-1:0]        channel;
    logic                      last_in_line;
    logic                      run_complete;
    logic [WORD_W-1:0]         adc_used;
    logic [WORD_W-1:0]         packets_ready;
    logic                      error_code;

    modport source (output valid, output kind, output value, output channel,
                    output last_in_line, output run_complete, output adc_used,
                    output packets_ready, output error_code, input ready);
    modport sink   (input valid, input kind, input value, input channel,
                    input last_in_line, input run_complete, input adc_used,
                    input packets_ready, input error_code, output ready);
endinterface

// ===== rtl/core/spd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module spd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sample_packet_deframer.sv =====
// Top level of the sample packet deframer.
`timescale 1ns / 1ps

// The block takes acquisition packets one 16-bit word at a time: a 0xF0AA
// header, a sequence number that must match the expected count, the converter
// memory used word, the packets ready word, and then the sample words. Sample
// words are stored in a 16-entry group buffer RAM; when a scan group (highest
// listed channel plus one words) is complete, the listed channels are read
// back in list order and sent out as offset binary or as signed Q4.16 volts.
// A header or sequence error produces one error word and halts the block
// until a restart word arrives; reaching the line limit also halts it. A
// word that completes an emitted group then holds the input while each
// listed channel in turn is read from the buffer RAM and then converted and
// loaded into the output register, the load waiting while that register is
// still held. Configuration writes are taken at any time through the plain
// write port and must only be made while the block is idle.

module sample_packet_deframer
    import spd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    spd_word_if.sink               i_word_ch,
    spd_result_if.source           o_result_ch
);

    // Configuration registers.
    logic [4:0]                       r_channel_count;
    logic [NUM_ENTRIES*ENTRY_W-1:0]   r_channel_table;
    logic                             r_output_mode;
    logic [1:0]                       r_range_select;
    logic [31:0]                      r_line_limit;
    logic                             r_show_status;

    // Packet tracking state.
    logic [POS_W-1:0]  r_word_position, n_word_position;
    logic [4:0]        r_group_fill, n_group_fill;
    logic [GRP_W-1:0]  r_groups_done, n_groups_done;
    logic [WORD_W-1:0] r_expected_count, n_expected_count;
    logic [31:0]       r_lines_left, n_lines_left;
    logic              r_first_dropped, n_first_dropped;
    logic [WORD_W-1:0] r_adc_used_latch, n_adc_used_latch;
    logic              r_halted, n_halted;
    logic              r_done, n_done;

    // Emission sequencer.
    t_state             r_state, n_state;
    logic [ENTRY_W-1:0] r_idx, n_idx;

    // Output register.
    logic                      r_out_valid, n_out_valid;
    t_kind                     r_out_kind, n_out_kind;
    logic signed [VALUE_W-1:0] r_out_value, n_out_value;
    logic [ENTRY_W-1:0]        r_out_channel, n_out_channel;
    logic                      r_out_last, n_out_last;
    logic                      r_out_complete, n_out_complete;
    logic [WORD_W-1:0]         r_out_adc, n_out_adc;
    logic [WORD_W-1:0]         r_out_ready_word, n_out_ready_word;
    logic                      r_out_err, n_out_err;

    logic                      out_free;
    logic                      word_acc;
    logic                      emit_start;
    logic                      load_sample;
    logic                      ram_we;
    logic                      ram_re;
    logic [WORD_W-1:0]         ram_rdata;
    logic [4:0]                used_cnt;
    logic [NUM_ENTRIES-1:0]    chan_mask;
    logic [4:0]                group_size;
    logic [GRP_W-1:0]          group_total;
    logic [ENTRY_W-1:0]        cur_chan;
    logic                      cur_last;
    logic signed [VALUE_W-1:0] cur_value;
    logic [31:0]               lines_base;

    // Converts a raw two's-complement word to signed Q4.16 volts. The scale
    // 65536/32767 equals 2 + 2/32767, so the result is 2m plus a small
    // rounded quotient by 32767 that a shift and one correction give.
    function automatic logic signed [VALUE_W-1:0] to_volts(input logic [WORD_W-1:0] raw,
                                                          input logic five);
        logic        neg;
        logic [16:0] mag;
        logic [18:0] m;
        logic [19:0] x;
        logic [4:0]  q0;
        logic [15:0] rem;
        logic [4:0]  qd;
        logic [19:0] q;
        logic [VALUE_W-1:0] qs;
        neg = raw[15];
        mag = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        m   = five ? (19'({mag, 2'b00}) + 19'(mag))
                   : (19'({mag, 3'b000}) + 19'({mag, 1'b0}));
        x   = {m, 1'b0} + 20'd16383;
        q0  = x[19:15];
        rem = {1'b0, x[14:0]} + 16'(q0);
        qd  = q0 + ((rem >= 16'd32767) ? 5'd1 : 5'd0);
        q   = {m, 1'b0} + 20'(qd);
        qs  = ({1'b0, q} > QMAX) ? QMAX : {1'b0, q};
        return neg ? -$signed(qs) : $signed(qs);
    endfunction

    assign out_free = !r_out_valid || o_result_ch.ready;
    assign word_acc = i_word_ch.valid && i_word_ch.ready;

    // Entries in use: zero counts as one, large values saturate.
    always_comb begin
        if (r_channel_count == 5'd0) begin
            used_cnt = 5'd1;
        end else if (r_channel_count > 5'(MAX_CHANNELS)) begin
            used_cnt = 5'(MAX_CHANNELS);
        end else begin
            used_cnt = r_channel_count;
        end
    end

    // Group size is the highest listed channel plus one.
    always_comb begin
        chan_mask = '0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (5'(i) < used_cnt) begin
                chan_mask[r_channel_table[i*ENTRY_W +: ENTRY_W]] = 1'b1;
            end
        end
        group_size = 5'd1;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (chan_mask[i]) begin
                group_size = 5'(i + 1);
            end
        end
    end

    assign group_total = groups_per_packet(group_size);

    assign cur_chan = r_channel_table[r_idx*ENTRY_W +: ENTRY_W];
    assign cur_last = ({1'b0, r_idx} + 5'd1) == used_cnt;
    assign lines_base = (r_lines_left == 32'd0) ? r_line_limit : r_lines_left;

    always_comb begin
        if (r_output_mode) begin
            cur_value = to_volts(ram_rdata,
                                 (cur_chan <= 4'd5) ? r_range_select[0] : r_range_select[1]);
        end else begin
            cur_value = $signed({5'b0, ram_rdata ^ 16'h8000});
        end
    end

    // Next state of the emission sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (emit_start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    n_state = cur_last ? ST_IDLE : ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        i_word_ch.ready = 1'b0;
        ram_re          = 1'b0;
        load_sample     = 1'b0;
        unique case (r_state)
            ST_IDLE: i_word_ch.ready = out_free;
            ST_READ: ram_re = 1'b1;
            ST_LOAD: load_sample = out_free;
            default: ;
        endcase
    end

    // Packet parsing and output register loading.
    always_comb begin
        n_word_position  = r_word_position;
        n_group_fill     = r_group_fill;
        n_groups_done    = r_groups_done;
        n_expected_count = r_expected_count;
        n_lines_left     = r_lines_left;
        n_first_dropped  = r_first_dropped;
        n_adc_used_latch = r_adc_used_latch;
        n_halted         = r_halted;
        n_done           = r_done;
        n_idx            = r_idx;
        emit_start       = 1'b0;
        ram_we           = 1'b0;

        n_out_valid      = r_out_valid && !o_result_ch.ready;
        n_out_kind       = r_out_kind;
        n_out_value      = r_out_value;
        n_out_channel    = r_out_channel;
        n_out_last       = r_out_last;
        n_out_complete   = r_out_complete;
        n_out_adc        = r_out_adc;
        n_out_ready_word = r_out_ready_word;
        n_out_err        = r_out_err;

        if (word_acc) begin
            if (i_word_ch.restart) begin
                n_word_position = '0;
                n_group_fill    = '0;
                n_groups_done   = '0;
                n_first_dropped = 1'b0;
                n_halted        = 1'b0;
            end else if (!r_halted) begin
                n_word_position = (r_word_position == POS_W'(PACKET_WORDS - 1))
                                  ? '0 : r_word_position + 1'b1;
                if (r_word_position == POS_W'(0)) begin
                    n_group_fill  = '0;
                    n_groups_done = '0;
                    if (i_word_ch.packet_word != HEADER_WORD) begin
                        n_halted         = 1'b1;
                        n_out_valid      = 1'b1;
                        n_out_kind       = KIND_ERROR;
                        n_out_value      = '0;
                        n_out_channel    = '0;
                        n_out_last       = 1'b0;
                        n_out_complete   = 1'b0;
                        n_out_adc        = '0;
                        n_out_ready_word = '0;
                        n_out_err        = ERR_HEADER;
                    end
                end else if (r_word_position == POS_W'(1)) begin
                    if (i_word_ch.packet_word != r_expected_count) begin
                        n_halted         = 1'b1;
                        n_out_valid      = 1'b1;
                        n_out_kind       = KIND_ERROR;
                        n_out_value      = '0;
                        n_out_channel    = '0;
                        n_out_last       = 1'b0;
                        n_out_complete   = 1'b0;
                        n_out_adc        = '0;
                        n_out_ready_word = '0;
                        n_out_err        = ERR_SEQUENCE;
                    end else begin
                        n_expected_count = r_expected_count + 1'b1;
                    end
                end else if (r_word_position == POS_W'(2)) begin
                    n_adc_used_latch = i_word_ch.packet_word;
                end else if (r_word_position == POS_W'(3)) begin
                    if (r_show_status) begin
                        n_out_valid      = 1'b1;
                        n_out_kind       = KIND_STATUS;
                        n_out_value      = '0;
                        n_out_channel    = '0;
                        n_out_last       = 1'b0;
                        n_out_complete   = 1'b0;
                        n_out_adc        = r_adc_used_latch;
                        n_out_ready_word = i_word_ch.packet_word;
                        n_out_err        = ERR_HEADER;
                    end
                end else if (!r_show_status && (r_groups_done < group_total)) begin
                    ram_we       = 1'b1;
                    n_group_fill = r_group_fill + 1'b1;
                    if ((r_group_fill + 5'd1) >= group_size) begin
                        n_group_fill  = '0;
                        n_groups_done = r_groups_done + 1'b1;
                        if (!r_first_dropped) begin
                            n_first_dropped = 1'b1;
                        end else begin
                            emit_start = 1'b1;
                            n_idx      = '0;
                            n_done     = 1'b0;
                            if (r_line_limit != 32'd0) begin
                                n_lines_left = lines_base - 1'b1;
                                if (lines_base == 32'd1) begin
                                    n_done   = 1'b1;
                                    n_halted = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
        end

        if (load_sample) begin
            n_out_valid      = 1'b1;
            n_out_kind       = KIND_SAMPLE;
            n_out_value      = cur_value;
            n_out_channel    = cur_chan;
            n_out_last       = cur_last;
            n_out_complete   = cur_last && r_done;
            n_out_adc        = '0;
            n_out_ready_word = '0;
            n_out_err        = ERR_HEADER;
            n_idx            = r_idx + 1'b1;
        end

        // Writing the start count also loads the expected sequence number.
        if (i_cfg_we && (i_cfg_index == REG_START_COUNT)) begin
            n_expected_count = i_cfg_data[WORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= 5'd1;
            r_channel_table <= '0;
            r_output_mode   <= 1'b0;
            r_range_select  <= 2'd0;
            r_line_limit    <= 32'd0;
            r_show_status   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[4:0];
                REG_CHANNEL_TABLE: r_channel_table <= i_cfg_data;
                REG_OUTPUT_MODE:   r_output_mode   <= i_cfg_data[0];
                REG_RANGE_SELECT:  r_range_select  <= i_cfg_data[1:0];
                REG_LINE_LIMIT:    r_line_limit    <= i_cfg_data[31:0];
                REG_SHOW_STATUS:   r_show_status   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_idx            <= '0;
            r_word_position  <= '0;
            r_group_fill     <= '0;
            r_groups_done    <= '0;
            r_expected_count <= '0;
            r_lines_left     <= '0;
            r_first_dropped  <= 1'b0;
            r_adc_used_latch <= '0;
            r_halted         <= 1'b0;
            r_done           <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_idx            <= n_idx;
            r_word_position  <= n_word_position;
            r_group_fill     <= n_group_fill;
            r_groups_done    <= n_groups_done;
            r_expected_count <= n_expected_count;
            r_lines_left     <= n_lines_left;
            r_first_dropped  <= n_first_dropped;
            r_adc_used_latch <= n_adc_used_latch;
            r_halted         <= n_halted;
            r_done           <= n_done;
            r_out_valid      <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind       <= n_out_kind;
        r_out_value      <= n_out_value;
        r_out_channel    <= n_out_channel;
        r_out_last       <= n_out_last;
        r_out_complete   <= n_out_complete;
        r_out_adc        <= n_out_adc;
        r_out_ready_word <= n_out_ready_word;
        r_out_err        <= n_out_err;
    end

    spd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_ENTRIES)
    ) u_group_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_group_fill[ENTRY_W-1:0]),
        .i_wdata (i_word_ch.packet_word),
        .i_re    (ram_re),
        .i_raddr (cur_chan),
        .o_rdata (ram_rdata)
    );

    assign o_result_ch.valid         = r_out_valid;
    assign o_result_ch.kind          = r_out_kind;
    assign o_result_ch.value         = r_out_value;
    assign o_result_ch.channel       = r_out_channel;
    assign o_result_ch.last_in_line  = r_out_last;
    assign o_result_ch.run_complete  = r_out_complete;
    assign o_result_ch.adc_used      = r_out_adc;
    assign o_result_ch.packets_ready = r_out_ready_word;
    assign o_result_ch.error_code    = r_out_err;

    // No new word is taken while a line is being read out.
    a_no_accept_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_word_ch.ready)
        else $error("word accepted during line read-out");

    // A pending error word always leaves the block halted.
    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_ERROR)) |-> r_halted)
        else $error("error word without halt");

    // The word that reaches the line limit leaves the block halted.
    a_complete_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_complete) |-> (r_halted && r_out_last))
        else $error("run complete without halt");

    // The group fill never points past the buffer.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_group_fill < 5'(NUM_ENTRIES))
        else $error("group fill out of range");

endmodule

// ===== tb/sample_packet_deframer_tb.sv =====
// Self-checking testbench for the sample packet deframer top level.
`timescale 1ns / 1ps

module sample_packet_deframer_tb;
    import spd_pkg::*;

    // The run is cut off at this many clock cycles. The slowest correct run,
    // with full lines of 16 channels and every stall, stays well below it.
    localparam int CYCLE_LIMIT  = 1_000_000;
    // Cycles to let pass before a register write.
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int NUM_PHASES   = 7;

    // One result word as the block should send it.
    typedef struct {
        t_kind                     kind;
        logic signed [VALUE_W-1:0] value;
        logic [ENTRY_W-1:0]        channel;
        logic                      last_in_line;
        logic                      run_complete;
        logic [WORD_W-1:0]         adc_used;
        logic [WORD_W-1:0]         packets_ready;
        t_err                      error_code;
    } t_result;

    // One row of the directed part. Where has_typed is set, the row's
    // expected result is typed in; otherwise the predictor supplies it.
    typedef struct {
        logic              restart;
        logic [WORD_W-1:0] word;
        bit                has_typed;
        t_result           typed;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    spd_word_if   word_ch();
    spd_result_if result_ch();

    sample_packet_deframer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_word_ch   (word_ch),
        .o_result_ch (result_ch)
    );

    // Shadow copy of the configuration registers.
    logic [4:0]  cfg_channel_count;
    logic [63:0] cfg_channel_table;
    logic        cfg_volts;
    logic [1:0]  cfg_range;
    logic [31:0] cfg_line_limit;
    logic        cfg_status;
    logic [15:0] cfg_start_count;

    // Shadow copy of the deframing state.
    int unsigned    packet_pos;
    int unsigned    fill_count;
    int unsigned    groups_seen;
    logic [15:0]    scan_group [16];
    logic [15:0]    next_sequence;
    logic [31:0]    lines_remaining;
    bit             first_group_gone;
    logic [15:0]    adc_used_word;
    bit             stopped;

    t_result pending_results[$];
    int      failures;
    int      cycles;
    bit      sender_idles;
    bit      hold_request;
    bit      hold_taken;
    int      hold_count;

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** sample_packet_deframer: FAILED **");
            $finish;
        end
    end

    // Mirrors a register write into the shadow copy of the configuration.
    function automatic void shadow_write(t_reg_index idx, logic [63:0] data);
        case (idx)
            REG_CHANNEL_COUNT: cfg_channel_count = data[4:0];
            REG_CHANNEL_TABLE: cfg_channel_table = data;
            REG_OUTPUT_MODE:   cfg_volts = data[0];
            REG_RANGE_SELECT:  cfg_range = data[1:0];
            REG_LINE_LIMIT:    cfg_line_limit = data[31:0];
            REG_SHOW_STATUS:   cfg_status = data[0];
            REG_START_COUNT: begin
                cfg_start_count = data[15:0];
                next_sequence = data[15:0];
            end
            default: ;
        endcase
    endfunction

    function automatic t_result blank_result();
        t_result r;
        r.kind = KIND_SAMPLE;
        r.value = '0;
        r.channel = '0;
        r.last_in_line = 1'b0;
        r.run_complete = 1'b0;
        r.adc_used = '0;
        r.packets_ready = '0;
        r.error_code = ERR_HEADER;
        return r;
    endfunction

    function automatic logic [3:0] listed_channel(int unsigned i);
        return cfg_channel_table[4*i +: 4];
    endfunction

    // Converts a raw sample to Q4.16 volts. The range is 5 V where the
    // range bit of the channel's bank is set, 10 V otherwise.
    function automatic logic signed [VALUE_W-1:0] sample_volts(logic [15:0] raw,
                                                               logic [3:0] chan);
        longint s;
        longint span;
        longint num;
        longint mag;
        longint q;
        s = longint'($signed(raw));
        span = ((chan <= 4'd5) ? cfg_range[0] : cfg_range[1]) ? 5 : 10;
        num = s * span * 65536;
        mag = (num < 0) ? -num : num;
        q = (mag + 16383) / 32767;
        if (q > 655360) q = 655360;
        return VALUE_W'((num < 0) ? -q : q);
    endfunction

    // Advances the shadow state by one accepted word and queues the result
    // words that it should cause.
    function automatic void deframe_word(logic restart, logic [15:0] w);
        int unsigned pos;
        int unsigned used;
        int unsigned group_size;
        int unsigned line_done;
        t_result r;
        logic [3:0] ch;
        if (restart) begin
            packet_pos = 0;
            fill_count = 0;
            groups_seen = 0;
            first_group_gone = 0;
            stopped = 0;
            return;
        end
        if (stopped) return;
        pos = packet_pos;
        packet_pos = (pos + 1 >= PACKET_WORDS) ? 0 : pos + 1;
        r = blank_result();
        if (pos == 0) begin
            fill_count = 0;
            groups_seen = 0;
            if (w != HEADER_WORD) begin
                r.kind = KIND_ERROR;
                r.error_code = ERR_HEADER;
                pending_results.push_back(r);
                stopped = 1;
            end
            return;
        end
        if (pos == 1) begin
            if (w != next_sequence) begin
                r.kind = KIND_ERROR;
                r.error_code = ERR_SEQUENCE;
                pending_results.push_back(r);
                stopped = 1;
            end else begin
                next_sequence = next_sequence + 16'd1;
            end
            return;
        end
        if (pos == 2) begin
            adc_used_word = w;
            return;
        end
        if (pos == 3) begin
            if (cfg_status) begin
                r.kind = KIND_STATUS;
                r.adc_used = adc_used_word;
                r.packets_ready = w;
                pending_results.push_back(r);
            end
            return;
        end
        if (cfg_status) return;

        // Zero listed channels counts as one; more than sixteen saturates.
        used = (cfg_channel_count == 0) ? 1 : cfg_channel_count;
        if (used > MAX_CHANNELS) used = MAX_CHANNELS;
        group_size = 0;
        for (int unsigned i = 0; i < used; i++)
            if (listed_channel(i) + 1 > group_size) group_size = listed_channel(i) + 1;
        // Words past the last whole group of the packet are dropped.
        if (groups_seen >= SAMPLES_PER_PACKET / group_size) return;

        scan_group[fill_count & 15] = w;
        fill_count++;
        if (fill_count < group_size) return;
        fill_count = 0;
        groups_seen++;
        if (!first_group_gone) begin
            first_group_gone = 1;
            return;
        end

        line_done = 0;
        if (cfg_line_limit != 0) begin
            if (lines_remaining == 0) lines_remaining = cfg_line_limit;
            lines_remaining--;
            if (lines_remaining == 0) begin
                line_done = 1;
                stopped = 1;
            end
        end
        for (int unsigned i = 0; i < used; i++) begin
            ch = listed_channel(i);
            r = blank_result();
            r.channel = ch;
            r.value = cfg_volts ? sample_volts(scan_group[ch], ch)
                                : VALUE_W'(scan_group[ch] ^ 16'h8000);
            r.last_in_line = (i + 1 == used);
            r.run_complete = r.last_in_line && line_done;
            pending_results.push_back(r);
        end
    endfunction

    task automatic write_register(t_reg_index idx, logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        shadow_write(idx, data);
        @(posedge i_clk);
    endtask

    // Offers one word and waits until the block takes it. The valid stays
    // high into the next word unless a random idle cycle follows.
    task automatic send_word(logic restart, logic [15:0] w, bit has_typed = 0,
                             t_result typed = '{kind: KIND_SAMPLE, error_code: ERR_HEADER,
                                                default: '0});
        int unsigned before_size;
        word_ch.valid <= 1'b1;
        word_ch.restart <= restart;
        word_ch.packet_word <= w;
        do @(posedge i_clk); while (!word_ch.ready);
        before_size = pending_results.size();
        deframe_word(restart, w);
        if (has_typed) begin
            while (pending_results.size() > before_size) void'(pending_results.pop_back());
            pending_results.push_back(typed);
        end
        if (sender_idles && $urandom_range(99) < 19) begin
            word_ch.valid <= 1'b0;
            do @(posedge i_clk); while (sender_idles && $urandom_range(99) < 19);
        end
    endtask

    // Waits until every expected word has come and the block has settled.
    task automatic drain_results();
        word_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Samples lean toward the extremes of offset binary.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(11))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // The opening n_words words of one packet, mostly well formed. Now and
    // then the header or the sequence number is wrong, or a restart cuts
    // the packet short.
    task automatic send_packet(int n_words);
        logic [15:0] w;
        for (int j = 0; j < n_words && j < PACKET_WORDS; j++) begin
            if (j > 0 && $urandom_range(299) == 0) begin
                send_word(1'b1, 16'($urandom));
                return;
            end
            case (j)
                0: w = ($urandom_range(19) == 0) ? 16'($urandom) : HEADER_WORD;
                1: w = ($urandom_range(19) == 0) ? next_sequence + 16'($urandom_range(1, 65535))
                                                  : next_sequence;
                2, 3: w = 16'($urandom);
                default: w = pick_sample();
            endcase
            send_word(1'b0, w);
        end
    endtask

    // Result side: random ready, with one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            hold_taken <= 1'b0;
            hold_count <= 0;
        end else if (hold_count > 0) begin
            result_ch.ready <= 1'b0;
            hold_count <= hold_count - 1;
        end else if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_count <= HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= !sender_idles || ($urandom_range(99) >= 19);
        end
    end

    task automatic check_field(string name, longint exp_val, longint got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            failures++;
        end
    endtask

    // Compares each accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expectation waiting");
                failures++;
            end else begin
                e = pending_results.pop_front();
                check_field("kind", e.kind, result_ch.kind);
                check_field("value", e.value, result_ch.value);
                check_field("channel", e.channel, result_ch.channel);
                check_field("last_in_line", e.last_in_line, result_ch.last_in_line);
                check_field("run_complete", e.run_complete, result_ch.run_complete);
                check_field("adc_used", e.adc_used, result_ch.adc_used);
                check_field("packets_ready", e.packets_ready, result_ch.packets_ready);
                check_field("error_code", e.error_code, result_ch.error_code);
            end
        end
    end

    function automatic t_result typed_sample(logic [20:0] v);
        t_result r;
        r = blank_result();
        r.value = v;
        r.last_in_line = 1'b1;
        return r;
    endfunction

    function automatic t_result typed_error(t_err code);
        t_result r;
        r = blank_result();
        r.kind = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    initial begin
        t_row rows[$];
        t_row row;
        logic [63:0] table_val;
        logic [31:0] limit_val;

        failures = 0;
        cycles = 0;
        sender_idles = 1;
        hold_request = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_CHANNEL_COUNT;
        i_cfg_data = '0;
        word_ch.valid = 1'b0;
        word_ch.restart = 1'b0;
        word_ch.packet_word = '0;

        // Shadow state after reset.
        cfg_channel_count = 5'd1;
        cfg_channel_table = '0;
        cfg_volts = 0;
        cfg_range = '0;
        cfg_line_limit = '0;
        cfg_status = 0;
        cfg_start_count = '0;
        packet_pos = 0;
        fill_count = 0;
        groups_seen = 0;
        foreach (scan_group[i]) scan_group[i] = '0;
        next_sequence = '0;
        lines_remaining = '0;
        first_group_gone = 0;
        adc_used_word = '0;
        stopped = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset configuration: one channel, channel 0,
        // offset binary. A bad header halts; the first group is dropped; the
        // sample extremes map through the sign flip; a wrong sequence number
        // halts and the halted block ignores the next word.
        row = '{restart: 0, word: 16'h1234, has_typed: 1, typed: typed_error(ERR_HEADER)};
        rows.push_back(row);
        row = '{restart: 1, word: 16'hFFFF, has_typed: 0, typed: blank_result()};
        rows.push_back(row);
        row.restart = 0; row.word = HEADER_WORD; rows.push_back(row);
        row.word = 16'h0000; rows.push_back(row);
        row.word = 16'hABCD; rows.push_back(row);
        row.word = 16'h5555; rows.push_back(row);
        row.word = 16'h1111; rows.push_back(row);
        row = '{restart: 0, word: 16'h0000, has_typed: 1, typed: typed_sample(21'h8000)};
        rows.push_back(row);
        row = '{restart: 0, word: 16'hFFFF, has_typed: 1, typed: typed_sample(21'h7FFF)};
        rows.push_back(row);
        row = '{restart: 0, word: 16'h8000, has_typed: 1, typed: typed_sample(21'h0000)};
        rows.push_back(row);
        row = '{restart: 0, word: 16'h7FFF, has_typed: 1, typed: typed_sample(21'hFFFF)};
        rows.push_back(row);
        row = '{restart: 1, word: 16'h0000, has_typed: 0, typed: blank_result()};
        rows.push_back(row);
        row.restart = 0; row.word = HEADER_WORD; rows.push_back(row);
        row = '{restart: 0, word: 16'h0005, has_typed: 1, typed: typed_error(ERR_SEQUENCE)};
        rows.push_back(row);
        row = '{restart: 0, word: 16'h0001, has_typed: 0, typed: blank_result()};
        rows.push_back(row);
        row.restart = 1; rows.push_back(row);

        foreach (rows[i]) send_word(rows[i].restart, rows[i].word, rows[i].has_typed,
                                    rows[i].typed);
        drain_results();

        // Random part: each phase loads a new setting while the block is
        // idle, restarts it, and sends the opening words of one packet.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: table_val = 64'hFEDC_BA98_7654_3210;
                1: table_val = '0;
                2: table_val = 64'hFFFF_FFFF_FFFF_FFFF;
                default: table_val = {32'($urandom), 32'($urandom)} & {16{4'($urandom)}};
            endcase
            case ($urandom_range(3))
                0: limit_val = '0;
                1: limit_val = 32'hFFFF_FFFF;
                default: limit_val = $urandom_range(1, 3);
            endcase
            write_register(REG_CHANNEL_COUNT, (p == 0) ? 64'd16 : (p == 1) ? 64'd0
                                              : 64'($urandom_range(31)));
            write_register(REG_CHANNEL_TABLE, table_val);
            write_register(REG_OUTPUT_MODE, (p == 0) ? 64'd1 : 64'($urandom_range(1)));
            write_register(REG_RANGE_SELECT, 64'(p % 4));
            write_register(REG_LINE_LIMIT, limit_val);
            write_register(REG_SHOW_STATUS, (p == 4) ? 64'd1 : 64'd0);
            if (p == 0 || $urandom_range(2) == 0)
                write_register(REG_START_COUNT, (p == 0) ? 64'hFFFF : 64'($urandom));
            i_cfg_we <= 1'b0;

            // Phase 2 holds the result side back so the block backs up;
            // phase 3 runs with no idle cycles on either side.
            hold_request = (p == 2);
            sender_idles = (p != 3);
            send_word(1'b1, 16'($urandom));
            send_packet(48 + int'($urandom_range(8)));
            drain_results();
        end

        if (failures == 0) begin
            $display("** sample_packet_deframer: PASSED **");
        end else begin
            $display("** sample_packet_deframer: FAILED **");
        end
        $finish;
    end

endmodule
